### rtl/tsfn_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfn_pkg: shared types and constants of the transform stack block
// Item and record formats, operation and state codes, fixed point helpers.
// ---------------------------------------------------------------------------
package tsfn_pkg;

    localparam int STACK_DEPTH   = 8;
    localparam int FRACTION_BITS = 16;

    localparam int MAT_WORDS  = 16;
    localparam int STK_WORDS  = STACK_DEPTH * MAT_WORDS;
    localparam int STK_AW     = $clog2(STK_WORDS);
    localparam int STG_AW     = $clog2(MAT_WORDS);
    localparam int CNT_W      = $clog2(STACK_DEPTH + 1);

    // Accumulator holds up to four rounded products plus one word.
    localparam int ACC_W      = 64 - FRACTION_BITS + 3;
    // Sum of three squares of values below 2^30.
    localparam int SQ_W       = 62;
    localparam int ROOT_W     = 63;
    localparam int SQRT_STEPS = 32;
    localparam int STEP_W     = $clog2(SQRT_STEPS);
    // Quotient of the normal division is at most 2^FRACTION_BITS + 1.
    localparam int QUO_W      = FRACTION_BITS + 2;
    localparam int NUM_W      = 31 + FRACTION_BITS;
    localparam int DIV_W      = 32 + FRACTION_BITS;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_PUSH = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;
    localparam logic [1:0] KIND_TRI  = 2'd3;

    localparam logic [1:0] REC_NORMAL = 2'd0;
    localparam logic [1:0] REC_VERTEX = 2'd1;
    localparam logic [1:0] REC_ERROR  = 2'd2;

    localparam logic ERR_POP_EMPTY = 1'b0;
    localparam logic ERR_PUSH_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         row_index;
        logic signed [31:0] coord0;
        logic signed [31:0] coord1;
        logic signed [31:0] coord2;
        logic signed [31:0] coord3;
        logic signed [31:0] coord4;
        logic signed [31:0] coord5;
        logic signed [31:0] coord6;
        logic signed [31:0] coord7;
        logic signed [31:0] coord8;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         record_kind;
        logic               error_code;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               last;
    } out_item_t;

    typedef enum logic [5:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_STG_WRITE,
        OP_CNT_INC,
        OP_CNT_DEC,
        OP_CP_READ,
        OP_CP_WRITE,
        OP_MM_READ,
        OP_MM_MUL,
        OP_MM_ACC,
        OP_MM_WRITE,
        OP_XF_READ_T,
        OP_XF_LOAD,
        OP_XF_READ,
        OP_XF_MUL,
        OP_XF_ACC,
        OP_XF_WRITE,
        OP_V_COPY,
        OP_EDGE,
        OP_CR_MUL_A,
        OP_CR_LOAD,
        OP_CR_MUL_B,
        OP_CR_SUB,
        OP_MAG,
        OP_NORM,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE,
        OP_EMIT_RES,
        OP_EMIT_ERR
    } dp_op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_CP_READ,
        ST_CP_WRITE,
        ST_MM_READ,
        ST_MM_MUL,
        ST_MM_ACC,
        ST_MM_WRITE,
        ST_PUSH_DONE,
        ST_XF_READ_T,
        ST_XF_LOAD,
        ST_XF_READ,
        ST_XF_MUL,
        ST_XF_ACC,
        ST_XF_WRITE,
        ST_EDGE,
        ST_CR_MUL_A,
        ST_CR_LOAD,
        ST_CR_MUL_B,
        ST_CR_SUB,
        ST_MAG,
        ST_CHECK,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_INIT,
        ST_SQRT_STEP,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_DIV_DONE,
        ST_EMIT,
        ST_ERR
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] term;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       count_zero;
        logic       count_full;
        logic       mag_zero;
        logic       norm_ok;
        logic       out_free;
    } dp_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [31:0]      res;
        hi = ACC_W'(signed'(32'h7FFFFFFF));
        lo = ACC_W'(signed'(32'h80000000));
        if (v > hi) begin
            res = 32'sh7FFFFFFF;
        end
        else if (v < lo) begin
            res = signed'(32'h80000000);
        end
        else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Edge indexes of the cross product terms: comp = a*b - c*d.
    function automatic logic [2:0] cross_sel(input logic [1:0] comp, input logic [1:0] term);
        logic [2:0] res;
        case ({comp, term})
            4'b00_00: res = 3'd1;
            4'b00_01: res = 3'd5;
            4'b00_10: res = 3'd2;
            4'b00_11: res = 3'd4;
            4'b01_00: res = 3'd2;
            4'b01_01: res = 3'd3;
            4'b01_10: res = 3'd0;
            4'b01_11: res = 3'd5;
            4'b10_00: res = 3'd0;
            4'b10_01: res = 3'd4;
            4'b10_10: res = 3'd1;
            4'b10_11: res = 3'd3;
            default:  res = 3'd0;
        endcase
        return res;
    endfunction

endpackage

### rtl/transform_stack_facet_normal.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// transform_stack_facet_normal: matrix stack, vertex transform, facet normal
// A sequencer and a datapath with one shared 32x32 multiplier.
// ---------------------------------------------------------------------------
// Load writes one staged row, pop drops the top matrix, push stores the staged matrix,
// or the top matrix times it if the stack is not empty. A triangle takes its 9
// coordinates through the top matrix if any, then cross product, normalizing, root,
// 3 divides and 4 beats out; a zero normal gives none. Full push, empty pop: error.
// Throughput: one item at a time, taken once any last beat sits in the output register.
// Reset: asynchronous, active low; clears the stack count and output valid.
// ---------------------------------------------------------------------------
module transform_stack_facet_normal (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  tsfn_pkg::in_item_t   item,
    output logic                 record_valid,
    input  logic                 record_stall,
    output tsfn_pkg::out_item_t  record
);

    // Command from the sequencer to the datapath, status back.
    tsfn_pkg::dp_cmd_t    cmd;
    tsfn_pkg::dp_status_t status;

    // The sequencer steps each item through the memory reads, multiply and
    // accumulate passes, root and divide iterations, and the output beats.
    tsfn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // The datapath holds the stack and staged matrices in memories, the item
    // being worked on, and the record register that drives the output side.
    tsfn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .record_valid (record_valid),
        .record_stall (record_stall),
        .record       (record)
    );

endmodule

### rtl/tsfn_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfn_ram: generic memory
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module tsfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tsfn_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfn_ctrl: sequencer of the transform stack block
// Walks each item through its steps and commands the datapath.
// ---------------------------------------------------------------------------
module tsfn_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  tsfn_pkg::dp_status_t  status,
    output tsfn_pkg::dp_cmd_t     cmd
);

    tsfn_pkg::state_t             state_reg, state_next;
    logic [1:0]                   row_reg, row_next;
    logic [1:0]                   col_reg, col_next;
    logic [1:0]                   term_reg, term_next;
    logic [tsfn_pkg::STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsfn_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            term_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            term_reg  <= term_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        term_next  = term_reg;
        step_next  = step_reg;
        cmd.op     = tsfn_pkg::OP_NOP;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.term   = term_reg;
        item_stall = (state_reg != tsfn_pkg::ST_IDLE);

        case (state_reg)
            tsfn_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = tsfn_pkg::OP_CAPTURE;
                    state_next = tsfn_pkg::ST_DISPATCH;
                end
            end
            tsfn_pkg::ST_DISPATCH:
            begin
                row_next  = '0;
                col_next  = '0;
                term_next = '0;
                step_next = '0;
                case (status.kind)
                    tsfn_pkg::KIND_LOAD: state_next = tsfn_pkg::ST_LOAD;
                    tsfn_pkg::KIND_PUSH:
                    begin
                        if (status.count_full)
                            state_next = tsfn_pkg::ST_ERR;
                        else if (status.count_zero)
                            state_next = tsfn_pkg::ST_CP_READ;
                        else
                            state_next = tsfn_pkg::ST_MM_READ;
                    end
                    tsfn_pkg::KIND_POP:
                    begin
                        if (status.count_zero)
                        begin
                            state_next = tsfn_pkg::ST_ERR;
                        end
                        else
                        begin
                            cmd.op     = tsfn_pkg::OP_CNT_DEC;
                            state_next = tsfn_pkg::ST_IDLE;
                        end
                    end
                    default:
                    begin
                        if (status.count_zero)
                        begin
                            cmd.op     = tsfn_pkg::OP_V_COPY;
                            state_next = tsfn_pkg::ST_EDGE;
                        end
                        else
                        begin
                            state_next = tsfn_pkg::ST_XF_READ_T;
                        end
                    end
                endcase
            end
            tsfn_pkg::ST_LOAD:
            begin
                cmd.op   = tsfn_pkg::OP_STG_WRITE;
                col_next = col_reg + 2'd1;
                if (col_reg == 2'd3)
                    state_next = tsfn_pkg::ST_IDLE;
            end
            tsfn_pkg::ST_CP_READ:
            begin
                cmd.op     = tsfn_pkg::OP_CP_READ;
                state_next = tsfn_pkg::ST_CP_WRITE;
            end
            tsfn_pkg::ST_CP_WRITE:
            begin
                cmd.op              = tsfn_pkg::OP_CP_WRITE;
                {row_next, col_next} = {row_reg, col_reg} + 4'd1;
                if ({row_reg, col_reg} == 4'hF)
                    state_next = tsfn_pkg::ST_PUSH_DONE;
                else
                    state_next = tsfn_pkg::ST_CP_READ;
            end
            tsfn_pkg::ST_MM_READ:
            begin
                cmd.op     = tsfn_pkg::OP_MM_READ;
                state_next = tsfn_pkg::ST_MM_MUL;
            end
            tsfn_pkg::ST_MM_MUL:
            begin
                cmd.op     = tsfn_pkg::OP_MM_MUL;
                state_next = tsfn_pkg::ST_MM_ACC;
            end
            tsfn_pkg::ST_MM_ACC:
            begin
                cmd.op    = tsfn_pkg::OP_MM_ACC;
                term_next = term_reg + 2'd1;
                if (term_reg == 2'd3)
                    state_next = tsfn_pkg::ST_MM_WRITE;
                else
                    state_next = tsfn_pkg::ST_MM_READ;
            end
            tsfn_pkg::ST_MM_WRITE:
            begin
                cmd.op               = tsfn_pkg::OP_MM_WRITE;
                {row_next, col_next} = {row_reg, col_reg} + 4'd1;
                if ({row_reg, col_reg} == 4'hF)
                    state_next = tsfn_pkg::ST_PUSH_DONE;
                else
                    state_next = tsfn_pkg::ST_MM_READ;
            end
            tsfn_pkg::ST_PUSH_DONE:
            begin
                cmd.op     = tsfn_pkg::OP_CNT_INC;
                state_next = tsfn_pkg::ST_IDLE;
            end
            tsfn_pkg::ST_XF_READ_T:
            begin
                cmd.op     = tsfn_pkg::OP_XF_READ_T;
                state_next = tsfn_pkg::ST_XF_LOAD;
            end
            tsfn_pkg::ST_XF_LOAD:
            begin
                cmd.op     = tsfn_pkg::OP_XF_LOAD;
                term_next  = '0;
                state_next = tsfn_pkg::ST_XF_READ;
            end
            tsfn_pkg::ST_XF_READ:
            begin
                cmd.op     = tsfn_pkg::OP_XF_READ;
                state_next = tsfn_pkg::ST_XF_MUL;
            end
            tsfn_pkg::ST_XF_MUL:
            begin
                cmd.op     = tsfn_pkg::OP_XF_MUL;
                state_next = tsfn_pkg::ST_XF_ACC;
            end
            tsfn_pkg::ST_XF_ACC:
            begin
                cmd.op = tsfn_pkg::OP_XF_ACC;
                if (term_reg == 2'd2)
                begin
                    term_next  = '0;
                    state_next = tsfn_pkg::ST_XF_WRITE;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = tsfn_pkg::ST_XF_READ;
                end
            end
            tsfn_pkg::ST_XF_WRITE:
            begin
                cmd.op     = tsfn_pkg::OP_XF_WRITE;
                state_next = tsfn_pkg::ST_XF_READ_T;
                if (row_reg == 2'd2)
                begin
                    row_next = '0;
                    if (col_reg == 2'd2)
                    begin
                        col_next   = '0;
                        state_next = tsfn_pkg::ST_EDGE;
                    end
                    else
                    begin
                        col_next = col_reg + 2'd1;
                    end
                end
                else
                begin
                    row_next = row_reg + 2'd1;
                end
            end
            tsfn_pkg::ST_EDGE:
            begin
                cmd.op     = tsfn_pkg::OP_EDGE;
                row_next   = '0;
                state_next = tsfn_pkg::ST_CR_MUL_A;
            end
            tsfn_pkg::ST_CR_MUL_A:
            begin
                cmd.op     = tsfn_pkg::OP_CR_MUL_A;
                state_next = tsfn_pkg::ST_CR_LOAD;
            end
            tsfn_pkg::ST_CR_LOAD:
            begin
                cmd.op     = tsfn_pkg::OP_CR_LOAD;
                state_next = tsfn_pkg::ST_CR_MUL_B;
            end
            tsfn_pkg::ST_CR_MUL_B:
            begin
                cmd.op     = tsfn_pkg::OP_CR_MUL_B;
                state_next = tsfn_pkg::ST_CR_SUB;
            end
            tsfn_pkg::ST_CR_SUB:
            begin
                cmd.op = tsfn_pkg::OP_CR_SUB;
                if (row_reg == 2'd2)
                begin
                    row_next   = '0;
                    state_next = tsfn_pkg::ST_MAG;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = tsfn_pkg::ST_CR_MUL_A;
                end
            end
            tsfn_pkg::ST_MAG:
            begin
                cmd.op     = tsfn_pkg::OP_MAG;
                state_next = tsfn_pkg::ST_CHECK;
            end
            tsfn_pkg::ST_CHECK:
            begin
                if (status.mag_zero)
                    state_next = tsfn_pkg::ST_IDLE;
                else
                    state_next = tsfn_pkg::ST_NORM;
            end
            tsfn_pkg::ST_NORM:
            begin
                if (status.norm_ok)
                begin
                    row_next   = '0;
                    state_next = tsfn_pkg::ST_SQ_MUL;
                end
                else
                begin
                    cmd.op = tsfn_pkg::OP_NORM;
                end
            end
            tsfn_pkg::ST_SQ_MUL:
            begin
                cmd.op     = tsfn_pkg::OP_SQ_MUL;
                state_next = tsfn_pkg::ST_SQ_ACC;
            end
            tsfn_pkg::ST_SQ_ACC:
            begin
                cmd.op = tsfn_pkg::OP_SQ_ACC;
                if (row_reg == 2'd2)
                begin
                    row_next   = '0;
                    state_next = tsfn_pkg::ST_SQRT_INIT;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = tsfn_pkg::ST_SQ_MUL;
                end
            end
            tsfn_pkg::ST_SQRT_INIT:
            begin
                cmd.op     = tsfn_pkg::OP_SQRT_INIT;
                step_next  = '0;
                state_next = tsfn_pkg::ST_SQRT_STEP;
            end
            tsfn_pkg::ST_SQRT_STEP:
            begin
                cmd.op    = tsfn_pkg::OP_SQRT_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == tsfn_pkg::STEP_W'(tsfn_pkg::SQRT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = tsfn_pkg::ST_DIV_INIT;
                end
            end
            tsfn_pkg::ST_DIV_INIT:
            begin
                cmd.op     = tsfn_pkg::OP_DIV_INIT;
                step_next  = '0;
                state_next = tsfn_pkg::ST_DIV_STEP;
            end
            tsfn_pkg::ST_DIV_STEP:
            begin
                cmd.op    = tsfn_pkg::OP_DIV_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == tsfn_pkg::STEP_W'(tsfn_pkg::QUO_W - 1))
                begin
                    step_next  = '0;
                    state_next = tsfn_pkg::ST_DIV_DONE;
                end
            end
            tsfn_pkg::ST_DIV_DONE:
            begin
                cmd.op = tsfn_pkg::OP_DIV_DONE;
                if (row_reg == 2'd2)
                begin
                    row_next   = '0;
                    state_next = tsfn_pkg::ST_EMIT;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = tsfn_pkg::ST_DIV_INIT;
                end
            end
            tsfn_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op   = tsfn_pkg::OP_EMIT_RES;
                    row_next = row_reg + 2'd1;
                    if (row_reg == 2'd3)
                        state_next = tsfn_pkg::ST_IDLE;
                end
            end
            tsfn_pkg::ST_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.op     = tsfn_pkg::OP_EMIT_ERR;
                    state_next = tsfn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsfn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/tsfn_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsfn_dp: datapath of the transform stack block
// Stack and staged memories, one shared multiplier, the accumulator, the
// root and divide iterations and the record output register.
// ---------------------------------------------------------------------------
module tsfn_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tsfn_pkg::in_item_t    item,
    input  tsfn_pkg::dp_cmd_t     cmd,
    output tsfn_pkg::dp_status_t  status,
    output logic                  record_valid,
    input  logic                  record_stall,
    output tsfn_pkg::out_item_t   record
);

    localparam int F   = tsfn_pkg::FRACTION_BITS;
    localparam int AW  = tsfn_pkg::ACC_W;

    // Control state.
    logic [tsfn_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           out_valid_reg, out_valid_next;

    // Payload state.
    tsfn_pkg::in_item_t             item_reg;
    tsfn_pkg::out_item_t            out_reg;
    logic signed [63:0]             prod_reg;
    logic signed [AW-1:0]           acc_reg;
    logic signed [31:0]             v_reg [9];
    logic signed [31:0]             e_reg [6];
    logic signed [63:0]             crs_reg;
    logic signed [64:0]             cr_reg [3];
    logic                           neg_reg [3];
    logic [63:0]                    m_reg [3];
    logic [63:0]                    mx_reg;
    logic [tsfn_pkg::SQ_W-1:0]      sum_reg;
    logic [tsfn_pkg::SQ_W-1:0]      rad_reg;
    logic [tsfn_pkg::ROOT_W-1:0]    res_reg;
    logic [tsfn_pkg::ROOT_W-1:0]    bit_reg;
    logic [tsfn_pkg::NUM_W-1:0]     drem_reg;
    logic [tsfn_pkg::DIV_W-1:0]     dvs_reg;
    logic [tsfn_pkg::QUO_W-1:0]     quo_reg;
    logic signed [31:0]             n_reg [3];

    // Memory ports.
    logic                           stk_we;
    logic [tsfn_pkg::STK_AW-1:0]    stk_waddr, stk_raddr;
    logic [31:0]                    stk_wdata, stk_rdata;
    logic                           stg_we;
    logic [tsfn_pkg::STG_AW-1:0]    stg_waddr, stg_raddr;
    logic [31:0]                    stg_wdata, stg_rdata;

    logic [tsfn_pkg::CNT_W-1:0]     top;
    logic signed [31:0]             coord [9];
    logic [3:0]                     cidx;
    logic [3:0]                     vidx;
    logic [3:0]                     vbase;
    logic signed [31:0]             mul_a, mul_b;
    logic signed [64:0]             rnd_full;
    logic signed [AW-1:0]           rnd;
    logic signed [32:0]             e_diff [6];
    logic                           big;
    logic [63:0]                    mag_abs [3];
    logic [63:0]                    mag_max;
    logic [tsfn_pkg::ROOT_W:0]      sq_trial;
    logic [30:0]                    root;
    logic [tsfn_pkg::NUM_W-1:0]     div_num;
    logic [2:0]                     sel_a, sel_b;

    tsfn_ram #(
        .WIDTH (32),
        .DEPTH (tsfn_pkg::STK_WORDS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    tsfn_ram #(
        .WIDTH (32),
        .DEPTH (tsfn_pkg::MAT_WORDS)
    ) u_staged_ram (
        .clk   (clk),
        .we    (stg_we),
        .waddr (stg_waddr),
        .wdata (stg_wdata),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    assign coord[0] = item_reg.coord0;
    assign coord[1] = item_reg.coord1;
    assign coord[2] = item_reg.coord2;
    assign coord[3] = item_reg.coord3;
    assign coord[4] = item_reg.coord4;
    assign coord[5] = item_reg.coord5;
    assign coord[6] = item_reg.coord6;
    assign coord[7] = item_reg.coord7;
    assign coord[8] = item_reg.coord8;

    assign top   = count_reg - 1'b1;
    assign cidx  = 4'(cmd.col) * 4'd3 + 4'(cmd.term);
    assign vidx  = 4'(cmd.col) * 4'd3 + 4'(cmd.row);
    assign vbase = 4'(cmd.row - 2'd1) * 4'd3;
    assign root  = res_reg[30:0];
    assign sel_a = tsfn_pkg::cross_sel(cmd.row, (cmd.op == tsfn_pkg::OP_CR_MUL_A) ? 2'd0 : 2'd2);
    assign sel_b = tsfn_pkg::cross_sel(cmd.row, (cmd.op == tsfn_pkg::OP_CR_MUL_A) ? 2'd1 : 2'd3);

    // Memory addressing.
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = (tsfn_pkg::STK_AW'(count_reg) << tsfn_pkg::STG_AW)
                    | tsfn_pkg::STK_AW'({cmd.row, cmd.col});
        stk_wdata = stg_rdata;
        stk_raddr = (tsfn_pkg::STK_AW'(top) << tsfn_pkg::STG_AW)
                    | tsfn_pkg::STK_AW'({cmd.row, cmd.term});
        stg_we    = 1'b0;
        stg_waddr = {item_reg.row_index, cmd.col};
        stg_wdata = coord[4'(cmd.col)];
        stg_raddr = {cmd.term, cmd.col};
        case (cmd.op)
            tsfn_pkg::OP_STG_WRITE: stg_we = 1'b1;
            tsfn_pkg::OP_CP_READ:   stg_raddr = {cmd.row, cmd.col};
            tsfn_pkg::OP_CP_WRITE:  stk_we = 1'b1;
            tsfn_pkg::OP_MM_WRITE:
            begin
                stk_we    = 1'b1;
                stk_wdata = tsfn_pkg::sat32(acc_reg);
            end
            tsfn_pkg::OP_XF_READ_T:
            begin
                stk_raddr = (tsfn_pkg::STK_AW'(top) << tsfn_pkg::STG_AW)
                            | tsfn_pkg::STK_AW'({cmd.row, 2'd3});
            end
            default:
            begin
                stk_we = 1'b0;
            end
        endcase
    end

    // Operand selection of the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            tsfn_pkg::OP_MM_MUL:
            begin
                mul_a = stk_rdata;
                mul_b = stg_rdata;
            end
            tsfn_pkg::OP_XF_MUL:
            begin
                mul_a = stk_rdata;
                mul_b = coord[cidx];
            end
            tsfn_pkg::OP_CR_MUL_A, tsfn_pkg::OP_CR_MUL_B:
            begin
                mul_a = e_reg[sel_a];
                mul_b = e_reg[sel_b];
            end
            tsfn_pkg::OP_SQ_MUL:
            begin
                mul_a = signed'({2'b00, m_reg[cmd.row][29:0]});
                mul_b = signed'({2'b00, m_reg[cmd.row][29:0]});
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Product rounded to the fraction, halves toward plus infinity.
    assign rnd_full = (signed'({prod_reg[63], prod_reg}) + 65'(1 << (F - 1))) >>> F;
    assign rnd      = rnd_full[AW-1:0];

    // Edge vectors, halved together when any leaves the word range.
    always_comb
    begin
        big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            e_diff[i]     = {v_reg[3 + i][31], v_reg[3 + i]} - {v_reg[i][31], v_reg[i]};
            e_diff[3 + i] = {v_reg[6 + i][31], v_reg[6 + i]} - {v_reg[i][31], v_reg[i]};
        end
        for (int i = 0; i < 6; i++)
        begin
            if (e_diff[i][32] != e_diff[i][31])
                big = 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_abs[i] = cr_reg[i][64] ? 64'(-cr_reg[i]) : cr_reg[i][63:0];
        end
        mag_max = mag_abs[0];
        if (mag_abs[1] > mag_max)
            mag_max = mag_abs[1];
        if (mag_abs[2] > mag_max)
            mag_max = mag_abs[2];
    end

    assign sq_trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign div_num  = (tsfn_pkg::NUM_W'(m_reg[cmd.row][29:0]) << F)
                      + tsfn_pkg::NUM_W'(root >> 1);

    always_comb
    begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !record_stall)
            out_valid_next = 1'b0;
        case (cmd.op)
            tsfn_pkg::OP_CNT_INC: count_next = count_reg + 1'b1;
            tsfn_pkg::OP_CNT_DEC: count_next = count_reg - 1'b1;
            tsfn_pkg::OP_EMIT_RES, tsfn_pkg::OP_EMIT_ERR: out_valid_next = 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tsfn_pkg::OP_CAPTURE:  item_reg <= item;
            tsfn_pkg::OP_MM_MUL, tsfn_pkg::OP_XF_MUL, tsfn_pkg::OP_CR_MUL_A,
            tsfn_pkg::OP_CR_MUL_B, tsfn_pkg::OP_SQ_MUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            tsfn_pkg::OP_MM_ACC:
            begin
                acc_reg <= ((cmd.term == 2'd0) ? AW'(0) : acc_reg) + rnd;
            end
            tsfn_pkg::OP_XF_LOAD:  acc_reg <= AW'(signed'(stk_rdata));
            tsfn_pkg::OP_XF_ACC:   acc_reg <= acc_reg + rnd;
            tsfn_pkg::OP_XF_WRITE: v_reg[vidx] <= tsfn_pkg::sat32(acc_reg);
            tsfn_pkg::OP_V_COPY:
            begin
                for (int i = 0; i < 9; i++)
                    v_reg[i] <= coord[i];
            end
            tsfn_pkg::OP_EDGE:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    if (big)
                        e_reg[i] <= 32'((e_diff[i] + 33'(e_diff[i][32])) >>> 1);
                    else
                        e_reg[i] <= e_diff[i][31:0];
                end
            end
            tsfn_pkg::OP_CR_LOAD:  crs_reg <= prod_reg;
            tsfn_pkg::OP_CR_SUB:
            begin
                cr_reg[cmd.row] <= {crs_reg[63], crs_reg} - {prod_reg[63], prod_reg};
            end
            tsfn_pkg::OP_MAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    m_reg[i]   <= mag_abs[i];
                    neg_reg[i] <= cr_reg[i][64];
                end
                mx_reg <= mag_max;
            end
            tsfn_pkg::OP_NORM:
            begin
                if (mx_reg[63:30] != '0)
                begin
                    mx_reg <= mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= m_reg[i] >> 1;
                end
                else
                begin
                    mx_reg <= mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                        m_reg[i] <= m_reg[i] << 1;
                end
            end
            tsfn_pkg::OP_SQ_ACC:
            begin
                sum_reg <= ((cmd.row == 2'd0) ? tsfn_pkg::SQ_W'(0) : sum_reg)
                           + prod_reg[tsfn_pkg::SQ_W-1:0];
            end
            tsfn_pkg::OP_SQRT_INIT:
            begin
                rad_reg <= sum_reg;
                res_reg <= '0;
                bit_reg <= tsfn_pkg::ROOT_W'(1) << (2 * (tsfn_pkg::SQRT_STEPS - 1));
            end
            tsfn_pkg::OP_SQRT_STEP:
            begin
                if ({2'b00, rad_reg} >= sq_trial)
                begin
                    rad_reg <= rad_reg - tsfn_pkg::SQ_W'(sq_trial);
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            tsfn_pkg::OP_DIV_INIT:
            begin
                drem_reg <= div_num;
                dvs_reg  <= tsfn_pkg::DIV_W'(root) << (tsfn_pkg::QUO_W - 1);
                quo_reg  <= '0;
            end
            tsfn_pkg::OP_DIV_STEP:
            begin
                if (tsfn_pkg::DIV_W'(drem_reg) >= dvs_reg)
                begin
                    drem_reg <= drem_reg - tsfn_pkg::NUM_W'(dvs_reg);
                    quo_reg  <= {quo_reg[tsfn_pkg::QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg <= {quo_reg[tsfn_pkg::QUO_W-2:0], 1'b0};
                end
                dvs_reg <= dvs_reg >> 1;
            end
            tsfn_pkg::OP_DIV_DONE:
            begin
                n_reg[cmd.row] <= neg_reg[cmd.row] ? -signed'(32'(quo_reg))
                                                   : signed'(32'(quo_reg));
            end
            tsfn_pkg::OP_EMIT_RES:
            begin
                out_reg.error_code <= 1'b0;
                if (cmd.row == 2'd0)
                begin
                    out_reg.record_kind <= tsfn_pkg::REC_NORMAL;
                    out_reg.out_x       <= n_reg[0];
                    out_reg.out_y       <= n_reg[1];
                    out_reg.out_z       <= n_reg[2];
                    out_reg.last        <= 1'b0;
                end
                else
                begin
                    out_reg.record_kind <= tsfn_pkg::REC_VERTEX;
                    out_reg.out_x       <= v_reg[vbase];
                    out_reg.out_y       <= v_reg[vbase + 4'd1];
                    out_reg.out_z       <= v_reg[vbase + 4'd2];
                    out_reg.last        <= (cmd.row == 2'd3);
                end
            end
            tsfn_pkg::OP_EMIT_ERR:
            begin
                out_reg.record_kind <= tsfn_pkg::REC_ERROR;
                out_reg.error_code  <= (item_reg.kind == tsfn_pkg::KIND_PUSH)
                                       ? tsfn_pkg::ERR_PUSH_FULL : tsfn_pkg::ERR_POP_EMPTY;
                out_reg.out_x       <= '0;
                out_reg.out_y       <= '0;
                out_reg.out_z       <= '0;
                out_reg.last        <= 1'b1;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign status.kind       = item_reg.kind;
    assign status.count_zero = (count_reg == '0);
    assign status.count_full = (count_reg == tsfn_pkg::CNT_W'(tsfn_pkg::STACK_DEPTH));
    assign status.mag_zero   = (mx_reg == '0);
    assign status.norm_ok    = (mx_reg[63:30] == '0) && mx_reg[29];
    assign status.out_free   = !out_valid_reg || !record_stall;

    assign record_valid = out_valid_reg;
    assign record       = out_reg;

    // The stack never holds more matrices than it has room for.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= tsfn_pkg::CNT_W'(tsfn_pkg::STACK_DEPTH))
        else $error("stack count out of range");

    // A new record is only written when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tsfn_pkg::OP_EMIT_RES || cmd.op == tsfn_pkg::OP_EMIT_ERR)
        |-> status.out_free)
        else $error("record written over a waiting beat");

    // Squaring starts only on normalized magnitudes.
    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tsfn_pkg::OP_SQ_MUL) |-> status.norm_ok)
        else $error("magnitudes not normalized before squaring");

    // The root of a normalized sum of squares is at least 2^29.
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == tsfn_pkg::OP_DIV_INIT) |-> (res_reg[tsfn_pkg::ROOT_W-1:31] == '0
                                               && res_reg[30:29] != 2'b00))
        else $error("square root out of range");

endmodule
